FILE: design/wmir_pkg.sv
// Shared types, constants and table-geometry functions for the wavetable reader.
package wmir_pkg;

	localparam int CMD_Q_DEPTH = 4;
	localparam int OUT_Q_DEPTH = 4;
	localparam int DEF_FRAMES = 16;
	localparam int DEF_MIP_LEVELS = 11;
	localparam int DEF_TABLE_SIZE = 2048;

	localparam logic [16:0] MORPH_ONE = 17'h10000;
	localparam logic [1:0] STEP_FIRST = 2'd0;
	localparam logic [1:0] STEP_LAST = 2'd3;

	// kind codes carried on tuser
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic rd;
		logic wr_en;
		logic zero;
		logic [31:0] frac;
		logic [15:0] wgt;
		logic [15:0] wdata;
	} cmd_ctl_t;

	function automatic int lvl_size(input int k, input int ts);
		return ts >> k;
	endfunction

	function automatic int lvl_off(input int k, input int ts);
		int acc;
		acc = 0;
		for (int n = 0; n < k; n++) begin
			acc += (ts >> n);
		end
		return acc;
	endfunction

	function automatic int store_depth(input int frames, input int mips, input int ts);
		return frames * lvl_off(mips, ts);
	endfunction

endpackage

FILE: design/wmir_queue.sv
// Small register FIFO used for the command queue and the result buffer.
module wmir_queue #(
	parameter int W = 16,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic push, pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: design/wmir_front.sv
// Front end: takes items, clamps and checks fields, computes table addresses and weights.
module wmir_front #(
	parameter int FRAMES = wmir_pkg::DEF_FRAMES,
	parameter int MIP_LEVELS = wmir_pkg::DEF_MIP_LEVELS,
	parameter int TABLE_SIZE = wmir_pkg::DEF_TABLE_SIZE,
	parameter int ADDR_W = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       kind,
	input  logic [3:0]                 frame_sel,
	input  logic [3:0]                 mip_level,
	input  logic [10:0]                write_index,
	input  logic [15:0]                write_value,
	input  logic [16:0]                morph_position,
	input  logic [31:0]                phase,
	output logic                       cmd_valid,
	input  logic                       cmd_ready,
	output wmir_pkg::cmd_ctl_t         cmd_ctl,
	output logic [3:0][ADDR_W-1:0]     cmd_addr
);
	import wmir_pkg::*;

	localparam int STRIDE = lvl_off(MIP_LEVELS, TABLE_SIZE);
	localparam int FR_W = $clog2(FRAMES);
	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int N_W = $clog2(TABLE_SIZE + 1);
	localparam int LV_W = (MIP_LEVELS > 1) ? $clog2(MIP_LEVELS) : 1;
	localparam int XW = 32 + N_W;
	localparam int PW = 17 + FR_W;

	logic [N_W-1:0] size_tab [MIP_LEVELS];
	logic [ADDR_W-1:0] off_tab [MIP_LEVELS];

	for (genvar k = 0; k < MIP_LEVELS; k++) begin : g_tab
		assign size_tab[k] = N_W'(lvl_size(k, TABLE_SIZE));
		assign off_tab[k] = ADDR_W'(lvl_off(k, TABLE_SIZE));
	end

	logic [3:0] lvl;
	logic [LV_W-1:0] lvl_idx;
	logic [N_W-1:0] n;
	logic [XW-1:0] x;
	logic [IDX_W-1:0] i, j;
	logic [N_W-1:0] i_nxt;
	logic [16:0] morph_sat;
	logic [PW-1:0] p;
	logic [FR_W-1:0] lower, upper;
	logic wr_ok;

	always_comb begin
		lvl = (mip_level >= 4'(MIP_LEVELS)) ? 4'(MIP_LEVELS - 1) : mip_level;
		lvl_idx = lvl[LV_W-1:0];
		n = size_tab[lvl_idx];
		x = XW'(phase) * XW'(n);
		i = x[32 +: IDX_W];
		i_nxt = N_W'(i) + 1'b1;
		// wrap to index zero in place of a guard sample
		j = (i_nxt == n) ? '0 : i_nxt[IDX_W-1:0];
		morph_sat = (morph_position > MORPH_ONE) ? MORPH_ONE : morph_position;
		p = PW'(morph_sat) * PW'(FRAMES - 1);
		lower = p[16 +: FR_W];
		upper = (lower == FR_W'(FRAMES - 1)) ? lower : lower + 1'b1;
		wr_ok = (n != '0) && (32'(write_index) < 32'(n)) && (32'(frame_sel) < 32'(FRAMES));
	end

	logic v_s1, rd_s1, wr_ok_s1, zero_s1;
	logic [ADDR_W-1:0] off_s1;
	logic [FR_W-1:0] lo_s1, hi_s1;
	logic [IDX_W-1:0] i_s1, j_s1;
	logic [31:0] f_s1;
	logic [15:0] w_s1, wd_s1;
	logic adv;

	assign in_ready = !v_s1 || cmd_ready;
	assign adv = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s1 <= (kind == KIND_READ);
			wr_ok_s1 <= wr_ok;
			zero_s1 <= (n == '0);
			off_s1 <= off_tab[lvl_idx];
			lo_s1 <= (kind == KIND_READ) ? lower : FR_W'(frame_sel);
			hi_s1 <= upper;
			i_s1 <= (kind == KIND_READ) ? i : IDX_W'(write_index);
			j_s1 <= j;
			f_s1 <= x[31:0];
			w_s1 <= p[15:0];
			wd_s1 <= write_value;
		end
	end

	logic [ADDR_W-1:0] base_lo, base_hi;

	always_comb begin
		base_lo = ADDR_W'(lo_s1) * ADDR_W'(STRIDE) + off_s1;
		base_hi = ADDR_W'(hi_s1) * ADDR_W'(STRIDE) + off_s1;
		if (zero_s1) begin
			cmd_addr = '0;
		end else begin
			cmd_addr[0] = base_lo + ADDR_W'(i_s1);
			cmd_addr[1] = base_lo + ADDR_W'(j_s1);
			cmd_addr[2] = base_hi + ADDR_W'(i_s1);
			cmd_addr[3] = base_hi + ADDR_W'(j_s1);
		end
		cmd_ctl.rd = rd_s1;
		cmd_ctl.wr_en = wr_ok_s1;
		cmd_ctl.zero = zero_s1;
		cmd_ctl.frac = f_s1;
		cmd_ctl.wgt = w_s1;
		cmd_ctl.wdata = wd_s1;
	end

	assign cmd_valid = v_s1;

endmodule

FILE: design/wmir_back.sv
// Back end: sample memory, read sequencer and interpolation pipeline.
module wmir_back #(
	parameter int FRAMES = wmir_pkg::DEF_FRAMES,
	parameter int MIP_LEVELS = wmir_pkg::DEF_MIP_LEVELS,
	parameter int TABLE_SIZE = wmir_pkg::DEF_TABLE_SIZE,
	parameter int ADDR_W = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  wmir_pkg::cmd_ctl_t     cmd_ctl,
	input  logic [3:0][ADDR_W-1:0] cmd_addr,
	output logic                   res_valid,
	output logic [15:0]            res_data,
	input  logic                   res_taken
);
	import wmir_pkg::*;

	localparam int DEPTH = store_depth(FRAMES, MIP_LEVELS, TABLE_SIZE);
	localparam int CR_W = $clog2(OUT_Q_DEPTH + 1);

	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_q;
	logic [1:0] step_q;
	logic [CR_W-1:0] outst_q;
	logic credit_ok, go, mem_we, mem_re, start;
	logic [ADDR_W-1:0] mem_addr;

	// a read item only starts when the result buffer is sure to have room
	always_comb begin
		credit_ok = (outst_q < CR_W'(OUT_Q_DEPTH));
		go = cmd_valid && (!cmd_ctl.rd || step_q != STEP_FIRST || credit_ok);
		cmd_ready = go && (!cmd_ctl.rd || step_q == STEP_LAST);
		mem_we = go && !cmd_ctl.rd && cmd_ctl.wr_en;
		mem_re = go && cmd_ctl.rd;
		start = mem_re && (step_q == STEP_FIRST);
		mem_addr = cmd_addr[step_q];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= cmd_ctl.wdata;
		end
		rdata_q <= mem[mem_addr];
	end

	logic rvalid_q;
	logic [1:0] rstep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_FIRST;
			outst_q <= '0;
			rvalid_q <= 1'b0;
			rstep_q <= STEP_FIRST;
		end else begin
			if (mem_re) begin
				step_q <= step_q + 1'b1;
			end
			if (start && !res_taken) begin
				outst_q <= outst_q + 1'b1;
			end else if (res_taken && !start) begin
				outst_q <= outst_q - 1'b1;
			end
			rvalid_q <= mem_re;
			rstep_q <= step_q;
		end
	end

	logic [31:0] f_s1;
	logic [15:0] w_s1;
	logic zero_s1;
	logic signed [15:0] a0_q, b0_q, a1_q;

	always_ff @(posedge clk) begin
		if (mem_re && step_q == STEP_LAST) begin
			f_s1 <= cmd_ctl.frac;
			w_s1 <= cmd_ctl.wgt;
			zero_s1 <= cmd_ctl.zero;
		end
		if (rvalid_q) begin
			case (rstep_q)
				2'd0: a0_q <= rdata_q;
				2'd1: b0_q <= rdata_q;
				2'd2: a1_q <= rdata_q;
				default: ;
			endcase
		end
	end

	logic v_s2, v_s3, v_s4;
	logic signed [49:0] p0_s2, p1_s2;
	logic signed [15:0] a0_s2, a1_s2, sa_s3, sb_s3, sa_s4;
	logic [15:0] w_s2, w_s3;
	logic zero_s2, zero_s3, zero_s4;
	logic signed [33:0] pw_s4;
	logic signed [16:0] d0, d1, dm;
	logic signed [32:0] fs;
	logic signed [17:0] sa_n, sb_n, r_n;

	always_comb begin
		fs = $signed({1'b0, f_s1});
		d0 = 17'(b0_q) - 17'(a0_q);
		d1 = 17'($signed(rdata_q)) - 17'(a1_q);
		sa_n = 18'(a0_s2) + p0_s2[49:32];
		sb_n = 18'(a1_s2) + p1_s2[49:32];
		dm = 17'(sb_s3) - 17'(sa_s3);
		r_n = 18'(sa_s4) + pw_s4[33:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= rvalid_q && (rstep_q == STEP_LAST);
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		p0_s2 <= 50'(fs * d0);
		p1_s2 <= 50'(fs * d1);
		a0_s2 <= a0_q;
		a1_s2 <= a1_q;
		w_s2 <= w_s1;
		zero_s2 <= zero_s1;
		sa_s3 <= sa_n[15:0];
		sb_s3 <= sb_n[15:0];
		w_s3 <= w_s2;
		zero_s3 <= zero_s2;
		pw_s4 <= 34'($signed({1'b0, w_s3}) * dm);
		sa_s4 <= sa_s3;
		zero_s4 <= zero_s3;
	end

	assign res_valid = v_s4;
	assign res_data = zero_s4 ? 16'd0 : r_n[15:0];

endmodule

FILE: design/wavetable_morph_interpolated_reader_core.sv
// Top level of the morphing, mip-mapped wavetable reader.
// The front end accepts one item per cycle while the command queue has room and queues it as
// a command; the back end runs each command against one single-port sample memory. A write
// makes one access there, a read makes four in turn (two taps in each of the two neighboring
// frames), and the next read can start while the last one is still being interpolated. The
// sample memory is not cleared: an entry holds no defined value until it has been written.
module wavetable_morph_interpolated_reader_core #(
	parameter int FRAMES = wmir_pkg::DEF_FRAMES,
	parameter int MIP_LEVELS = wmir_pkg::DEF_MIP_LEVELS,
	parameter int TABLE_SIZE = wmir_pkg::DEF_TABLE_SIZE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// frame_sel, mip_level, write_index, write_value, morph_position, phase, zero pad
	input  logic [87:0] s_axis_tdata,
	// kind
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// sample_out
	output logic [15:0] m_axis_tdata
);
	import wmir_pkg::*;

	localparam int ADDR_W = $clog2(store_depth(FRAMES, MIP_LEVELS, TABLE_SIZE));
	localparam int CMD_W = $bits(cmd_ctl_t) + 4 * ADDR_W;

	logic f_valid, f_ready, b_valid, b_ready;
	cmd_ctl_t f_ctl, b_ctl;
	logic [3:0][ADDR_W-1:0] f_addr, b_addr;
	logic [CMD_W-1:0] q_in, q_out;
	logic res_valid;
	logic [15:0] res_data;
	logic out_pop;

	wmir_front #(
		.FRAMES(FRAMES), .MIP_LEVELS(MIP_LEVELS), .TABLE_SIZE(TABLE_SIZE), .ADDR_W(ADDR_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.kind(s_axis_tuser),
		.frame_sel(s_axis_tdata[3:0]),
		.mip_level(s_axis_tdata[7:4]),
		.write_index(s_axis_tdata[18:8]),
		.write_value(s_axis_tdata[34:19]),
		.morph_position(s_axis_tdata[51:35]),
		.phase(s_axis_tdata[83:52]),
		.cmd_valid(f_valid),
		.cmd_ready(f_ready),
		.cmd_ctl(f_ctl),
		.cmd_addr(f_addr)
	);

	assign q_in = {f_ctl, f_addr};
	assign {b_ctl, b_addr} = q_out;

	wmir_queue #(.W(CMD_W), .DEPTH(CMD_Q_DEPTH)) u_cmd_q (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data(q_in),
		.pop_valid(b_valid),
		.pop_ready(b_ready),
		.pop_data(q_out)
	);

	wmir_back #(
		.FRAMES(FRAMES), .MIP_LEVELS(MIP_LEVELS), .TABLE_SIZE(TABLE_SIZE), .ADDR_W(ADDR_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(b_valid),
		.cmd_ready(b_ready),
		.cmd_ctl(b_ctl),
		.cmd_addr(b_addr),
		.res_valid(res_valid),
		.res_data(res_data),
		.res_taken(out_pop)
	);

	assign out_pop = m_axis_tvalid && m_axis_tready;

	// room is reserved by the back end before a read starts, so push never stalls
	wmir_queue #(.W(16), .DEPTH(OUT_Q_DEPTH)) u_out_q (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(res_valid),
		.push_ready(),
		.push_data(res_data),
		.pop_valid(m_axis_tvalid),
		.pop_ready(m_axis_tready),
		.pop_data(m_axis_tdata)
	);

endmodule

FILE: design/wmir_checker.sv
// Port-level checks for the wavetable reader, bound to the top level.
module wmir_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);
	import wmir_pkg::*;

	logic [15:0] pend_q;
	logic in_rd, out_beat;

	assign in_rd = s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_READ);
	assign out_beat = m_axis_tvalid && m_axis_tready;

	// reads accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_rd && !out_beat) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_beat && !in_rd) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result data changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> pend_q != '0)
		else $error("result beat without a pending read");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("result valid right after reset");

	// a write beat never adds to the pending read count
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_WRITE) |=> pend_q == $past(pend_q)
			|| $past(out_beat))
		else $error("write beat changed the pending read count");

endmodule

bind wavetable_morph_interpolated_reader_core wmir_checker u_wmir_checker (.*);
